@@ rtl/core/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the square-root unit checkers.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define NSTT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A word that is offered and not taken stays offered and unchanged.
`define NSTT_ASSERT_HOLD(name, clk, rst_n, vld, rdy, data, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && !rdy) |=> (vld && $stable(data))) else $error(msg);

`endif

@@ rtl/core/nstt_pkg.sv @@
// ============================================================================
// Square root times ten package
// Widths, constants and shared types of the Newton square-root unit.
// ============================================================================
`default_nettype none

package nstt_pkg;

  localparam int unsigned InW      = 16;
  localparam int unsigned OutW     = 12;
  localparam int unsigned EstW     = 16;
  localparam int unsigned RadW     = 23;
  localparam int unsigned DivCntW  = $clog2(RadW);
  localparam int unsigned MaxSteps = 6;
  localparam int unsigned StepCntW = $clog2(MaxSteps);

  localparam logic [EstW-1:0] StartEst = 16'h00ff;
  localparam logic [6:0]      Scale    = 7'd100;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StDivide,
    StUpdate,
    StFinish
  } nstt_state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic update;
    logic out_load;
  } nstt_cmd_t;

  typedef struct packed {
    logic zero;
    logic div_done;
    logic converged;
    logic last_step;
  } nstt_status_t;

endpackage

`default_nettype wire

@@ rtl/core/nstt_in_if.sv @@
// ============================================================================
// Input channel
// Valid/ready channel that carries the value whose root is wanted.
// ============================================================================
`default_nettype none

interface nstt_in_if
  import nstt_pkg::*;
();

  logic            valid;
  logic            ready;
  logic [InW-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);

endinterface

`default_nettype wire

@@ rtl/core/nstt_out_if.sv @@
// ============================================================================
// Output channel
// Valid/ready channel that carries the root times ten.
// ============================================================================
`default_nettype none

interface nstt_out_if
  import nstt_pkg::*;
();

  logic             valid;
  logic             ready;
  logic [OutW-1:0]  root_times_ten;

  modport source (output valid, output root_times_ten, input ready);
  modport sink   (input valid, input root_times_ten, output ready);

endinterface

`default_nettype wire

@@ rtl/core/newton_sqrt_times_ten_unit.sv @@
// ============================================================================
// Newton square root times ten
// Returns the Newton estimate of the square root of a 16-bit value scaled by ten.
// ============================================================================
// Channel  Dir  Payload               Width
// in_i     in   value                 16
// out_o    out  root_times_ten        12
//
// A nonzero word runs up to MaxSteps Newton steps; each step uses the
// one-bit-per-cycle divider shared by all steps.
// A zero word skips the divider and goes from StStart straight to StFinish.
// The result sits in an output register, so a new word is taken while it waits.
// Reset is asynchronous and active low; it clears the controller and the
// divider's sequencing flags.
`default_nettype none

module newton_sqrt_times_ten_unit
  import nstt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  nstt_in_if.sink       in_i,
  nstt_out_if.source    out_o
);

  nstt_cmd_t    cmd;
  nstt_status_t status;
  logic         in_ready;
  logic         out_valid;
  logic [OutW-1:0] result;

  nstt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nstt_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .value_i  (in_i.value),
    .status_o (status),
    .result_o (result)
  );

  assign in_i.ready           = in_ready;
  assign out_o.valid          = out_valid;
  assign out_o.root_times_ten = result;

endmodule

`default_nettype wire

@@ rtl/core/nstt_div.sv @@
// ============================================================================
// Restoring divider
// Divides the radicand by the estimate, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module nstt_div
  import nstt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RadW-1:0]  dividend_i,
  input  wire logic [EstW-1:0]  divisor_i,
  output logic                  done_o,
  output logic [RadW-1:0]       quot_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [EstW-1:0]    rem_q, rem_d;
  logic [RadW-1:0]    quo_q;
  logic [EstW-1:0]    dsr_q;
  logic [EstW:0]      shifted;
  logic               ge;

  always_comb begin
    shifted = {rem_q, quo_q[RadW-1]};
    ge      = shifted >= {1'b0, dsr_q};
    if (ge) begin
      rem_d = EstW'(shifted - {1'b0, dsr_q});
    end else begin
      rem_d = shifted[EstW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(RadW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[RadW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/nstt_datapath.sv @@
// ============================================================================
// Square root datapath
// Holds the radicand and estimates, runs the divider, keeps the result word.
// ============================================================================
`default_nettype none

module nstt_datapath
  import nstt_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nstt_cmd_t     cmd_i,
  input  wire logic [InW-1:0] value_i,
  output nstt_status_t       status_o,
  output logic [OutW-1:0]    result_o
);

  logic [RadW-1:0]     rad_q;
  logic [EstW-1:0]     est_q;
  logic [EstW-1:0]     prev_q;
  logic [StepCntW-1:0] step_q;
  logic                zero_q;
  logic [OutW-1:0]     result_q;
  logic                div_done;
  logic [RadW-1:0]     div_quot;
  logic [EstW-1:0]     quot;
  logic [EstW:0]       sum;
  logic [EstW-1:0]     est_next;

  nstt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rad_q),
    .divisor_i  (est_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    quot     = (est_q == '0) ? '0 : div_quot[EstW-1:0];
    sum      = {1'b0, est_q} + {1'b0, quot};
    est_next = sum[EstW:1];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rad_q  <= RadW'(value_i) * RadW'(Scale);
      zero_q <= (value_i == '0);
      est_q  <= (value_i == '0) ? '0 : StartEst;
      prev_q <= '0;
      step_q <= '0;
    end else if (cmd_i.update) begin
      est_q  <= est_next;
      prev_q <= est_next;
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      result_q <= est_q[OutW-1:0];
    end
  end

  assign status_o.zero      = zero_q;
  assign status_o.div_done  = div_done;
  assign status_o.converged = (est_next == prev_q);
  assign status_o.last_step = (step_q == StepCntW'(MaxSteps - 1));
  assign result_o           = result_q;

endmodule

`default_nettype wire

@@ rtl/core/nstt_ctrl.sv @@
// ============================================================================
// Square root controller
// Sequences load, division, Newton update and result hand-off.
// ============================================================================
`default_nettype none

module nstt_ctrl
  import nstt_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire nstt_status_t status_i,
  output nstt_cmd_t         cmd_o
);

  nstt_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StStart;
        end
      end
      StStart: begin
        state_d = status_i.zero ? StFinish : StDivide;
      end
      StDivide: begin
        if (status_i.div_done) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        if (status_i.converged || status_i.last_step) begin
          state_d = StFinish;
        end else begin
          state_d = StStart;
        end
      end
      StFinish: begin
        if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StStart: begin
        cmd_o.div_start = !status_i.zero;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
      end
      StFinish: begin
        cmd_o.out_load = slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/nstt_checker.sv @@
// ============================================================================
// Square root port checker
// Watches the top-level channels for ordering and hand-off errors.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module nstt_checker
  import nstt_pkg::*;
(
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic [InW-1:0]  in_value_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire logic [OutW-1:0] out_root_i
);

  `NSTT_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_i, out_ready_i, out_root_i, "Output word changed while stalled")

  `NSTT_ASSERT(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "Second word taken while one is in work")

  `NSTT_ASSERT(a_zero_fast, clk_i, rst_ni, (in_valid_i && in_ready_i && in_value_i == '0 && !out_valid_i) |-> ##3 (out_valid_i && out_root_i == '0), "Zero word not answered with zero in time")

endmodule

bind newton_sqrt_times_ten_unit nstt_checker u_nstt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_value_i  (in_i.value),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_root_i  (out_o.root_times_ten)
);

`default_nettype wire

@@ dv/newton_sqrt_times_ten_unit_test.sv @@
// ============================================================================
// Newton square root times ten unit test
// Sends 16-bit words through the input channel and checks every root times
// ten against a local bit-exact Newton predictor. The tests are directed
// edge values, back-to-back streams, receiver pressure, randomly gapped
// traffic and zero words mixed with slow nonzero words.
// ============================================================================
module newton_sqrt_times_ten_unit_test;
  import nstt_pkg::*;

  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic [InW-1:0]  value;
    logic [OutW-1:0] root;
  } root_expect_t;

  logic clk;
  logic rst_n;

  nstt_in_if  in_ch ();
  nstt_out_if out_ch ();

  newton_sqrt_times_ten_unit i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  root_expect_t pending_roots[$];
  int unsigned  mismatches;
  int unsigned  words_sent;
  int unsigned  roots_checked;
  int unsigned  cycle_cnt;
  int unsigned  ready_hold;
  bit           send_gaps;
  bit           accept_stalls;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned pick_gap(bit enable);
    int unsigned roll;
    if (!enable) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [OutW-1:0] predict_root(logic [InW-1:0] value);
    logic [31:0]   radicand;
    logic [EstW-1:0] est;
    logic [EstW-1:0] prev;
    logic [EstW-1:0] quot;
    logic [EstW:0]   sum;
    bit            done;
    radicand = {16'd0, value} * 32'd100;
    if (radicand == 32'd0) begin
      return '0;
    end
    est  = StartEst;
    prev = '0;
    done = 1'b0;
    for (int unsigned i = 0; i < MaxSteps && !done; i++) begin
      quot = '0;
      if (est != '0) begin
        quot = 16'(radicand / {16'd0, est});
      end
      sum = {1'b0, est} + {1'b0, quot};
      est = sum[EstW:1];
      if (est == prev) begin
        done = 1'b1;
      end
      prev = est;
    end
    return est[OutW-1:0];
  endfunction

  function automatic logic [InW-1:0] random_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) begin
      return InW'($urandom_range(0, 100));
    end else if (roll < 30) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return 16'd1;
        2: return 16'hffff;
        3: return 16'hfffe;
        default: return 16'h8000;
      endcase
    end
    return InW'($urandom_range(0, 65535));
  endfunction

  task automatic report_mismatch(string what, logic [InW-1:0] value,
                                 int unsigned exp_v, int unsigned got_v);
    $display("MISMATCH at cycle %0d: %s, value %0d, expected %0d, got %0d",
             cycle_cnt, what, value, exp_v, got_v);
    mismatches++;
  endtask

  // The valid stays high when the next word follows without a gap.
  task automatic send_value(logic [InW-1:0] value);
    int unsigned gap;
    root_expect_t item;
    gap = pick_gap(send_gaps);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    item.value = value;
    item.root  = predict_root(value);
    pending_roots.push_back(item);
    words_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_roots.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [InW-1:0] edge_values[$];
    edge_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd0, 16'd99, 16'd100,
                    16'd255, 16'd256, 16'd650, 16'd651, 16'd4096, 16'd10000,
                    16'h5555, 16'haaaa, 16'h7fff, 16'h8000, 16'd40000, 16'hfffe,
                    16'hffff, 16'd0, 16'hffff};
    send_gaps     = 1'b0;
    accept_stalls = 1'b0;
    foreach (edge_values[i]) begin
      send_value(edge_values[i]);
    end
    drain();
  endtask

  task automatic test_back_to_back();
    send_gaps     = 1'b0;
    accept_stalls = 1'b0;
    repeat (300) send_value(random_value());
    drain();
  endtask

  task automatic test_receiver_pressure();
    send_gaps     = 1'b0;
    accept_stalls = 1'b1;
    repeat (250) send_value(random_value());
    drain();
  endtask

  task automatic test_random_gaps();
    send_gaps     = 1'b1;
    accept_stalls = 1'b1;
    repeat (700) send_value(random_value());
    drain();
  endtask

  task automatic test_zero_mix();
    send_gaps     = 1'b1;
    accept_stalls = 1'b1;
    repeat (130) begin
      if ($urandom_range(0, 1) == 0) begin
        send_value('0);
      end else begin
        send_value(random_value());
      end
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold     <= ready_hold - 1;
      out_ch.ready   <= 1'b0;
    end else begin
      out_ch.ready   <= 1'b1;
      ready_hold     <= pick_gap(accept_stalls);
    end
  end

  always @(posedge clk) begin
    root_expect_t item;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("result with no word pending", '0, 0,
                        32'(out_ch.root_times_ten));
      end else begin
        item = pending_roots.pop_front();
        roots_checked++;
        if (out_ch.root_times_ten !== item.root) begin
          report_mismatch("root_times_ten", item.value, 32'(item.root),
                          32'(out_ch.root_times_ten));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending.",
               cycle_cnt, pending_roots.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    ready_hold    = 0;
    send_gaps     = 1'b0;
    accept_stalls = 1'b0;
    mismatches    = 0;
    words_sent    = 0;
    roots_checked = 0;
    cycle_cnt     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_receiver_pressure();
    test_random_gaps();
    test_zero_mix();

    $display("Sent %0d words and checked %0d roots across directed, back-to-back,",
             words_sent, roots_checked);
    $display("stalled and gapped traffic; %0d mismatches in %0d cycles.",
             mismatches, cycle_cnt);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
